@@ design/line_endpoint_camera_rotation_defines.svh @@
// Assertion macros for the line endpoint camera rotation block.
`ifndef LINE_ENDPOINT_CAMERA_ROTATION_DEFINES_SVH
`define LINE_ENDPOINT_CAMERA_ROTATION_DEFINES_SVH

`ifndef ASSERT_OFF
`define LECR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LECR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LECR_ASSERT(lbl, prop, msg)
`define LECR_ASSERT_RST(lbl, prop, msg)
`endif

`endif

@@ design/lecr_pkg.sv @@
// Shared types and constants of the line endpoint camera rotation block.
`default_nettype none

package lecr_pkg;

  // stage enables of the two registers of one rotation stage
  typedef struct packed {
    logic en_a;
    logic en_b;
  } rot_ctl_t;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAM_POS_X   = 3'd0,
    REG_CAM_POS_Y   = 3'd1,
    REG_CAM_POS_Z   = 3'd2,
    REG_YAW_ANGLE   = 3'd3,
    REG_PITCH_ANGLE = 3'd4,
    REG_ROLL_ANGLE  = 3'd5
  } cfg_reg_t;

  typedef enum logic [6:0] {
    TR_IDLE  = 7'b0000001,
    TR_SETUP = 7'b0000010,
    TR_MUL   = 7'b0000100,
    TR_USE   = 7'b0001000,
    TR_RECIP = 7'b0010000,
    TR_DIV   = 7'b0100000,
    TR_FIX   = 7'b1000000
  } tr_state_t;

  typedef enum logic [2:0] {
    SLOT_YAW_SIN   = 3'd0,
    SLOT_YAW_COS   = 3'd1,
    SLOT_PITCH_SIN = 3'd2,
    SLOT_PITCH_COS = 3'd3,
    SLOT_ROLL_SIN  = 3'd4,
    SLOT_ROLL_COS  = 3'd5
  } slot_t;

  localparam int TURN_BITS = 32;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [31:0] PI_HALF_Q30 = 32'd1686629713;

  // sequencer steps: x, x squared, five Horner divisions, final sine product
  localparam logic [2:0] STEP_X   = 3'd0;
  localparam logic [2:0] STEP_X2  = 3'd1;
  localparam logic [2:0] STEP_SIN = 3'd7;

  // Taylor divisor of each Horner step
  function automatic logic [6:0] div_const(input logic [2:0] step);
    logic [6:0] k;
    case (step)
      3'd2: k = 7'd110;
      3'd3: k = 7'd72;
      3'd4: k = 7'd42;
      3'd5: k = 7'd20;
      3'd6: k = 7'd6;
      default: k = 7'd1;
    endcase
    return k;
  endfunction

  // floor(2^shift / divisor); the estimate it gives is at most one below the quotient
  function automatic logic [31:0] div_recip(input logic [2:0] step);
    logic [31:0] m;
    case (step)
      3'd2: m = 32'd2498890063;
      3'd3: m = 32'd3817748707;
      3'd4: m = 32'd3272356035;
      3'd5: m = 32'd3435973836;
      3'd6: m = 32'd2863311530;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] div_shift(input logic [2:0] step);
    logic [5:0] sh;
    case (step)
      3'd2: sh = 6'd38;
      3'd3: sh = 6'd38;
      3'd4: sh = 6'd37;
      3'd5: sh = 6'd36;
      3'd6: sh = 6'd34;
      default: sh = 6'd32;
    endcase
    return sh;
  endfunction

endpackage

`default_nettype wire

@@ design/line_endpoint_camera_rotation.sv @@
// Line endpoint camera rotation: a seven-stage pipeline rotates both endpoints and the
// camera position by yaw, pitch and roll, one item per clock unless the sequencer is busy
// or the output stalls; result_valid rises as the output register takes the item, and a
// full output register lets the next item enter while a result waits. Sine and cosine of
// the three angles come from a sequencer with one shared 32x32 multiplier that also
// divides by the Taylor constants through a reciprocal product and one correction step;
// it runs after reset and after every angle register write, and item_ready stays low
// until it is done. Camera position writes take effect on the next item.
`default_nettype none
`include "line_endpoint_camera_rotation_defines.svh"

module line_endpoint_camera_rotation
  import lecr_pkg::*;
#(
  parameter int COORD_WIDTH    = 32,
  parameter int ANGLE_WIDTH    = 16,
  parameter int TRIG_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic [CFG_IDX_W-1:0]              cfg_index,
  input  logic [((COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH)-1:0] cfg_data,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic signed [COORD_WIDTH-1:0]     p1_x,
  input  logic signed [COORD_WIDTH-1:0]     p1_y,
  input  logic signed [COORD_WIDTH-1:0]     p1_z,
  input  logic signed [COORD_WIDTH-1:0]     p2_x,
  input  logic signed [COORD_WIDTH-1:0]     p2_y,
  input  logic signed [COORD_WIDTH-1:0]     p2_z,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic signed [COORD_WIDTH-1:0]     r1_x,
  output logic signed [COORD_WIDTH-1:0]     r1_y,
  output logic signed [COORD_WIDTH-1:0]     r1_z,
  output logic signed [COORD_WIDTH-1:0]     r2_x,
  output logic signed [COORD_WIDTH-1:0]     r2_y,
  output logic signed [COORD_WIDTH-1:0]     r2_z,
  output logic signed [COORD_WIDTH-1:0]     rc_x,
  output logic signed [COORD_WIDTH-1:0]     rc_y,
  output logic signed [COORD_WIDTH-1:0]     rc_z,
  output logic                              visible
);

  localparam int TRIG_W = TRIG_FRAC_BITS + 2;
  localparam logic [32:0] ROUND_BIAS = 33'(1) << (29 - TRIG_FRAC_BITS);
  localparam logic [32:0] TRIG_ONE   = 33'(1) << TRIG_FRAC_BITS;

  // configuration registers
  logic signed [COORD_WIDTH-1:0] cam_pos_x, cam_pos_y, cam_pos_z;
  logic [ANGLE_WIDTH-1:0] yaw_angle, pitch_angle, roll_angle;
  logic angle_write;

  assign angle_write = cfg_write_en && (cfg_index == REG_YAW_ANGLE ||
                       cfg_index == REG_PITCH_ANGLE || cfg_index == REG_ROLL_ANGLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_pos_x   <= '0;
      cam_pos_y   <= '0;
      cam_pos_z   <= '0;
      yaw_angle   <= '0;
      pitch_angle <= '0;
      roll_angle  <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_CAM_POS_X:   cam_pos_x   <= cfg_data[COORD_WIDTH-1:0];
        REG_CAM_POS_Y:   cam_pos_y   <= cfg_data[COORD_WIDTH-1:0];
        REG_CAM_POS_Z:   cam_pos_z   <= cfg_data[COORD_WIDTH-1:0];
        REG_YAW_ANGLE:   yaw_angle   <= cfg_data[ANGLE_WIDTH-1:0];
        REG_PITCH_ANGLE: pitch_angle <= cfg_data[ANGLE_WIDTH-1:0];
        REG_ROLL_ANGLE:  roll_angle  <= cfg_data[ANGLE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- sine/cosine sequencer ----------------
  tr_state_t tr_state;
  slot_t     tr_slot;
  logic      tr_busy;
  logic [2:0]  tr_step;
  logic        tr_neg;
  logic [30:0] tr_rf, tr_x, tr_t;
  logic [31:0] tr_x2;
  logic [63:0] tr_prod;
  logic [31:0] div_n, div_q0, div_r;
  logic signed [TRIG_W-1:0] trig [6];

  logic [ANGLE_WIDTH-1:0] ang;
  logic [TURN_BITS-1:0]   turn;
  logic [1:0]  quad;
  logic [30:0] rf_next;
  logic [31:0] opa, opb, prod_hi;
  logic [31:0] recip, q_est, r_est, q_fix;
  logic [5:0]  div_sh;
  logic [6:0]  divisor;
  logic        fits;
  logic [32:0] s_full;
  logic [TRIG_W-1:0] s_mag;
  logic signed [TRIG_W-1:0] sig;

  assign tr_busy = (tr_state != TR_IDLE);

  always_comb begin
    case (tr_slot)
      SLOT_YAW_SIN, SLOT_YAW_COS:     ang = ANGLE_WIDTH'(0) - yaw_angle;
      SLOT_PITCH_SIN, SLOT_PITCH_COS: ang = ANGLE_WIDTH'(0) - pitch_angle;
      SLOT_ROLL_SIN, SLOT_ROLL_COS:   ang = roll_angle;
      default:                        ang = '0;
    endcase
    turn = {ang, {(TURN_BITS-ANGLE_WIDTH){1'b0}}};
    // cosine: advance a quarter turn
    quad = turn[TURN_BITS-1:TURN_BITS-2] + {1'b0, tr_slot[0]};
    rf_next = quad[0] ? (Q30_ONE - {1'b0, turn[29:0]}) : {1'b0, turn[29:0]};

    divisor = div_const(tr_step);
    recip   = div_recip(tr_step);
    div_sh  = div_shift(tr_step);

    if (tr_state == TR_RECIP) begin
      opa = div_n;
      opb = recip;
    end else begin
      case (tr_step)
        STEP_X: begin
          opa = {1'b0, tr_rf};
          opb = PI_HALF_Q30;
        end
        STEP_X2: begin
          opa = {1'b0, tr_x};
          opb = {1'b0, tr_x};
        end
        STEP_SIN: begin
          opa = {1'b0, tr_x};
          opb = {1'b0, tr_t};
        end
        default: begin
          opa = tr_x2;
          opb = {1'b0, tr_t};
        end
      endcase
    end
    prod_hi = tr_prod[61:30];

    // quotient estimate from the reciprocal product, then at most one step up
    q_est = 32'(tr_prod >> div_sh);
    r_est = div_n - q_est * {25'd0, divisor};
    fits  = (div_r >= {25'd0, divisor});
    q_fix = div_q0 + {31'd0, fits};

    // round to the trig scale, clamp to one, apply the half-turn sign
    s_full = ({1'b0, prod_hi} + ROUND_BIAS) >> (30 - TRIG_FRAC_BITS);
    if (s_full > TRIG_ONE) s_mag = TRIG_W'(TRIG_ONE);
    else s_mag = s_full[TRIG_W-1:0];
    sig = tr_neg ? -$signed(s_mag) : $signed(s_mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tr_state <= TR_SETUP;
      tr_slot  <= SLOT_YAW_SIN;
    end else if (angle_write) begin
      // restart all six values
      tr_state <= TR_SETUP;
      tr_slot  <= SLOT_YAW_SIN;
    end else begin
      case (tr_state)
        TR_IDLE:  ;
        TR_SETUP: tr_state <= TR_MUL;
        TR_MUL:   tr_state <= TR_USE;
        TR_USE: begin
          if (tr_step == STEP_SIN) begin
            if (tr_slot == SLOT_ROLL_COS) begin
              tr_state <= TR_IDLE;
            end else begin
              tr_state <= TR_SETUP;
              tr_slot  <= slot_t'(tr_slot + 3'd1);
            end
          end else if (tr_step == STEP_X || tr_step == STEP_X2) begin
            tr_state <= TR_MUL;
          end else begin
            tr_state <= TR_RECIP;
          end
        end
        TR_RECIP: tr_state <= TR_DIV;
        TR_DIV:   tr_state <= TR_FIX;
        TR_FIX:   tr_state <= TR_MUL;
        default:  tr_state <= TR_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (tr_state)
      TR_SETUP: begin
        tr_rf   <= rf_next;
        tr_neg  <= quad[1];
        tr_step <= STEP_X;
        tr_t    <= Q30_ONE;
      end
      TR_MUL, TR_RECIP: tr_prod <= opa * opb;
      TR_USE: begin
        case (tr_step)
          STEP_X: begin
            tr_x    <= prod_hi[30:0];
            tr_step <= tr_step + 3'd1;
          end
          STEP_X2: begin
            tr_x2   <= prod_hi;
            tr_step <= tr_step + 3'd1;
          end
          STEP_SIN: trig[tr_slot] <= sig;
          default: div_n <= prod_hi;
        endcase
      end
      TR_DIV: begin
        div_q0 <= q_est;
        div_r  <= r_est;
      end
      TR_FIX: begin
        tr_t    <= Q30_ONE - q_fix[30:0];
        tr_step <= tr_step + 3'd1;
      end
      default: ;
    endcase
  end

  // ---------------- rotation pipeline ----------------
  logic [7:1] vld, en;
  rot_ctl_t ctl_y, ctl_p, ctl_r;

  always_comb begin
    en[7] = !vld[7] || result_ready;
    for (int k = 6; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign item_ready   = en[1] && !tr_busy;
  assign result_valid = vld[7];

  assign ctl_y.en_a = en[1];
  assign ctl_y.en_b = en[2];
  assign ctl_p.en_a = en[3];
  assign ctl_p.en_b = en[4];
  assign ctl_r.en_a = en[5];
  assign ctl_r.en_b = en[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= item_valid && !tr_busy;
      for (int k = 2; k <= 7; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  logic signed [COORD_WIDTH-1:0] lane_x [3], lane_y [3], lane_z [3];
  logic signed [COORD_WIDTH-1:0] x1 [3], y1 [3], z1 [3];
  logic signed [COORD_WIDTH-1:0] x2 [3], y2 [3], z2 [3];
  logic signed [COORD_WIDTH-1:0] x3 [3], y3 [3], z3 [3];

  always_comb begin
    lane_x[0] = p1_x;
    lane_y[0] = p1_y;
    lane_z[0] = p1_z;
    lane_x[1] = p2_x;
    lane_y[1] = p2_y;
    lane_z[1] = p2_z;
    lane_x[2] = cam_pos_x;
    lane_y[2] = cam_pos_y;
    lane_z[2] = cam_pos_z;
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    // about Y by the negated yaw
    lecr_rot #(
      .COORD_WIDTH(COORD_WIDTH), .TRIG_WIDTH(TRIG_W), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_rot_yaw (
      .clk(clk), .ctl(ctl_y),
      .a(lane_z[g]), .b(lane_x[g]), .keep(lane_y[g]),
      .c(trig[SLOT_YAW_COS]), .s(trig[SLOT_YAW_SIN]),
      .first(x1[g]), .second(z1[g]), .kept(y1[g])
    );
    // about X by the negated pitch
    lecr_rot #(
      .COORD_WIDTH(COORD_WIDTH), .TRIG_WIDTH(TRIG_W), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_rot_pitch (
      .clk(clk), .ctl(ctl_p),
      .a(z1[g]), .b(y1[g]), .keep(x1[g]),
      .c(trig[SLOT_PITCH_COS]), .s(trig[SLOT_PITCH_SIN]),
      .first(y2[g]), .second(z2[g]), .kept(x2[g])
    );
    // about Z by the roll
    lecr_rot #(
      .COORD_WIDTH(COORD_WIDTH), .TRIG_WIDTH(TRIG_W), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_rot_roll (
      .clk(clk), .ctl(ctl_r),
      .a(x2[g]), .b(y2[g]), .keep(z2[g]),
      .c(trig[SLOT_ROLL_COS]), .s(trig[SLOT_ROLL_SIN]),
      .first(y3[g]), .second(x3[g]), .kept(z3[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      r1_x    <= x3[0];
      r1_y    <= y3[0];
      r1_z    <= z3[0];
      r2_x    <= x3[1];
      r2_y    <= y3[1];
      r2_z    <= z3[1];
      rc_x    <= x3[2];
      rc_y    <= y3[2];
      rc_z    <= z3[2];
      visible <= (z3[2] < z3[0]) || (z3[2] < z3[1]);
    end
  end

  // ---------------- assertions ----------------
  `LECR_ASSERT_RST(a_reset_starts_trig,
    rst |=> (tr_state == TR_SETUP) && (tr_slot == SLOT_YAW_SIN),
    "reset did not start the trig sequencer")
  `LECR_ASSERT(a_angle_write_restarts,
    angle_write |=> (tr_state == TR_SETUP) && (tr_slot == SLOT_YAW_SIN),
    "angle write did not restart the trig sequencer")
  `LECR_ASSERT(a_no_entry_while_busy,
    (tr_state != TR_IDLE) |-> !item_ready,
    "item accepted while trig values are being computed")
  `LECR_ASSERT(a_stall_keeps_item,
    (vld[6] && !en[6]) |=> vld[6],
    "stalled pipeline stage lost its item")

endmodule

`default_nettype wire

@@ design/lecr_rot.sv @@
// Rotation of a coordinate pair, registered as products and then as rounded, saturated sums.
`default_nettype none

module lecr_rot
  import lecr_pkg::*;
#(
  parameter int COORD_WIDTH    = 32,
  parameter int TRIG_WIDTH     = 18,
  parameter int TRIG_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  rot_ctl_t                      ctl,
  input  logic signed [COORD_WIDTH-1:0] a,
  input  logic signed [COORD_WIDTH-1:0] b,
  input  logic signed [COORD_WIDTH-1:0] keep,
  input  logic signed [TRIG_WIDTH-1:0]  c,
  input  logic signed [TRIG_WIDTH-1:0]  s,
  output logic signed [COORD_WIDTH-1:0] first,
  output logic signed [COORD_WIDTH-1:0] second,
  output logic signed [COORD_WIDTH-1:0] kept
);

  localparam int PROD_W = COORD_WIDTH + TRIG_WIDTH;
  localparam int SUM_W  = PROD_W + 1;
  localparam int SHR_W  = SUM_W - TRIG_FRAC_BITS;

  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (TRIG_FRAC_BITS - 1);
  localparam logic signed [SHR_W-1:0] SAT_MAX = SHR_W'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [SHR_W-1:0] SAT_MIN = -SAT_MAX - SHR_W'(1);

  logic signed [PROD_W-1:0] p_as, p_bc, p_ac, p_bs;
  logic signed [COORD_WIDTH-1:0] keep_a;
  logic signed [SUM_W-1:0] sum_first, sum_second;
  logic signed [SHR_W-1:0] sh_first, sh_second;

  function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [SHR_W-1:0] v);
    logic signed [COORD_WIDTH-1:0] r;
    if (v > SAT_MAX) r = COORD_WIDTH'(SAT_MAX);
    else if (v < SAT_MIN) r = COORD_WIDTH'(SAT_MIN);
    else r = v[COORD_WIDTH-1:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.en_a) begin
      p_as   <= a * s;
      p_bc   <= b * c;
      p_ac   <= a * c;
      p_bs   <= b * s;
      keep_a <= keep;
    end
  end

  // round half up, then floor by the trig scale
  always_comb begin
    sum_first  = SUM_W'(p_as) + SUM_W'(p_bc) + HALF;
    sum_second = SUM_W'(p_ac) - SUM_W'(p_bs) + HALF;
    sh_first   = SHR_W'(sum_first >>> TRIG_FRAC_BITS);
    sh_second  = SHR_W'(sum_second >>> TRIG_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (ctl.en_b) begin
      first  <= sat(sh_first);
      second <= sat(sh_second);
      kept   <= keep_a;
    end
  end

endmodule

`default_nettype wire

@@ tb/line_endpoint_camera_rotation_test.sv @@
// Self-checking testbench for the line endpoint camera rotation block.
`default_nettype none

module line_endpoint_camera_rotation_test;
  import lecr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 32;
  localparam int AW = 16;
  localparam int DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;
  localparam logic signed [CW-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [CW-1:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [CW-1:0] C_ONE = 32'sh0001_0000;
  localparam logic signed [CW-1:0] C_HALF = 32'sh0000_8000;
  localparam logic [63:0] Q30 = 64'h4000_0000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 137;

  // idle modes of a phase
  localparam int MODE_NONE = 0;
  localparam int MODE_SENDER = 1;
  localparam int MODE_RECEIVER = 2;
  localparam int MODE_BOTH = 3;

  typedef struct packed {
    logic signed [CW-1:0] p1_x, p1_y, p1_z, p2_x, p2_y, p2_z;
  } line_t;

  typedef struct packed {
    logic signed [CW-1:0] r1_x, r1_y, r1_z, r2_x, r2_y, r2_z, rc_x, rc_y, rc_z;
    logic visible;
  } view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_ready;
  logic result_valid;
  logic result_ready = 1'b0;
  line_t bus_line = '0;
  view_t got_view;

  // register copies kept in step with every write
  logic signed [CW-1:0] cam_x = '0, cam_y = '0, cam_z = '0;
  logic [AW-1:0] yaw = '0, pitch = '0, roll = '0;

  line_t pending_lines[$];
  view_t expected_views[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_count = 0;

  line_endpoint_camera_rotation dut (
    .clk, .rst, .cfg_write_en, .cfg_index, .cfg_data,
    .item_valid, .item_ready,
    .p1_x(bus_line.p1_x), .p1_y(bus_line.p1_y), .p1_z(bus_line.p1_z),
    .p2_x(bus_line.p2_x), .p2_y(bus_line.p2_y), .p2_z(bus_line.p2_z),
    .result_valid, .result_ready,
    .r1_x(got_view.r1_x), .r1_y(got_view.r1_y), .r1_z(got_view.r1_z),
    .r2_x(got_view.r2_x), .r2_y(got_view.r2_y), .r2_z(got_view.r2_z),
    .rc_x(got_view.rc_x), .rc_y(got_view.rc_y), .rc_z(got_view.rc_z),
    .visible(got_view.visible)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // sine of r (quarter-turn fraction in Q30) by a truncated Taylor series
  function automatic logic [63:0] quarter_sine_q30(input logic [63:0] r);
    logic [63:0] x, x2, t;
    x = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t = Q30;
    t = Q30 - ((x2 * t) >> 30) / 64'd110;
    t = Q30 - ((x2 * t) >> 30) / 64'd72;
    t = Q30 - ((x2 * t) >> 30) / 64'd42;
    t = Q30 - ((x2 * t) >> 30) / 64'd20;
    t = Q30 - ((x2 * t) >> 30) / 64'd6;
    return (x * t) >> 30;
  endfunction

  // sine of a 32-bit turn fraction with 16 fraction bits, clamped to +-1
  function automatic longint turn_sine(input logic [31:0] u);
    logic [63:0] r, m, s;
    r = {34'd0, u[29:0]};
    m = u[30] ? quarter_sine_q30(Q30 - r) : quarter_sine_q30(r);
    s = (m + 64'd8192) >> 14;
    if (s > 64'd65536) s = 64'd65536;
    return u[31] ? -longint'(s) : longint'(s);
  endfunction

  // round(a*p + b*q) / 2^16, half toward +inf, saturated to the coordinate range
  function automatic longint mix_round_sat(input longint a, input longint p,
                                           input longint b, input longint q);
    longint v;
    v = (a * p + b * q + 64'sd32768) >>> 16;
    if (v > SAT_HI) v = SAT_HI;
    if (v < SAT_LO) v = SAT_LO;
    return v;
  endfunction

  function automatic void rotate_xyz(inout longint x, inout longint y, inout longint z,
                                     input longint sy, input longint cy,
                                     input longint sp, input longint cp,
                                     input longint sr, input longint cr);
    longint x1, z1, y2, z2;
    x1 = mix_round_sat(z, sy, x, cy);
    z1 = mix_round_sat(z, cy, x, -sy);
    y2 = mix_round_sat(z1, sp, y, cp);
    z2 = mix_round_sat(z1, cp, y, -sp);
    x = mix_round_sat(x1, cr, y2, -sr);
    y = mix_round_sat(x1, sr, y2, cr);
    z = z2;
  endfunction

  function automatic view_t rotate_view(input line_t l);
    logic [AW-1:0] neg_yaw, neg_pitch;
    logic [31:0] ty, tp, tr;
    longint sy, cy, sp, cp, sr, cr;
    longint v [9];
    view_t res;
    neg_yaw = -yaw;
    neg_pitch = -pitch;
    ty = {neg_yaw, 16'd0};
    tp = {neg_pitch, 16'd0};
    tr = {roll, 16'd0};
    sy = turn_sine(ty);
    cy = turn_sine(ty + 32'h4000_0000);
    sp = turn_sine(tp);
    cp = turn_sine(tp + 32'h4000_0000);
    sr = turn_sine(tr);
    cr = turn_sine(tr + 32'h4000_0000);
    v[0] = l.p1_x; v[1] = l.p1_y; v[2] = l.p1_z;
    v[3] = l.p2_x; v[4] = l.p2_y; v[5] = l.p2_z;
    v[6] = cam_x; v[7] = cam_y; v[8] = cam_z;
    rotate_xyz(v[0], v[1], v[2], sy, cy, sp, cp, sr, cr);
    rotate_xyz(v[3], v[4], v[5], sy, cy, sp, cp, sr, cr);
    rotate_xyz(v[6], v[7], v[8], sy, cy, sp, cp, sr, cr);
    res.r1_x = v[0][CW-1:0]; res.r1_y = v[1][CW-1:0]; res.r1_z = v[2][CW-1:0];
    res.r2_x = v[3][CW-1:0]; res.r2_y = v[4][CW-1:0]; res.r2_z = v[5][CW-1:0];
    res.rc_x = v[6][CW-1:0]; res.rc_y = v[7][CW-1:0]; res.rc_z = v[8][CW-1:0];
    res.visible = (v[8] < v[2]) || (v[8] < v[5]);
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 100) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [CW-1:0] got,
                             input logic [CW-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // driver: hold the item until accepted, then load the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) expected_views.push_back(rotate_view(bus_line));
      if (!item_valid || item_ready) begin
        if (pending_lines.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          bus_line <= pending_lines.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    view_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_views.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = expected_views.pop_front();
          check_field("r1_x", got_view.r1_x, want.r1_x);
          check_field("r1_y", got_view.r1_y, want.r1_y);
          check_field("r1_z", got_view.r1_z, want.r1_z);
          check_field("r2_x", got_view.r2_x, want.r2_x);
          check_field("r2_y", got_view.r2_y, want.r2_y);
          check_field("r2_z", got_view.r2_z, want.r2_z);
          check_field("rc_x", got_view.rc_x, want.rc_x);
          check_field("rc_y", got_view.rc_y, want.rc_y);
          check_field("rc_z", got_view.rc_z, want.rc_z);
          check_field("visible", {31'd0, got_view.visible}, {31'd0, want.visible});
        end
      end
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_CAM_POS_X:   cam_x = value[CW-1:0];
      REG_CAM_POS_Y:   cam_y = value[CW-1:0];
      REG_CAM_POS_Z:   cam_z = value[CW-1:0];
      REG_YAW_ANGLE:   yaw = value[AW-1:0];
      REG_PITCH_ANGLE: pitch = value[AW-1:0];
      REG_ROLL_ANGLE:  roll = value[AW-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [DATA_W-1:0] cx, input logic [DATA_W-1:0] cy,
                           input logic [DATA_W-1:0] cz, input logic [DATA_W-1:0] ay,
                           input logic [DATA_W-1:0] ap, input logic [DATA_W-1:0] ar);
    write_reg(REG_CAM_POS_X, cx);
    write_reg(REG_CAM_POS_Y, cy);
    write_reg(REG_CAM_POS_Z, cz);
    write_reg(REG_YAW_ANGLE, ay);
    write_reg(REG_PITCH_ANGLE, ap);
    write_reg(REG_ROLL_ANGLE, ar);
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // wait until every item is accepted and every result is back, then let the pipe settle
  task automatic wait_drained();
    while (pending_lines.size() != 0 || item_valid || expected_views.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_mode(input int mode);
    @(posedge clk);
    send_idle_pct <= (mode == MODE_SENDER) ? 66 : (mode == MODE_BOTH) ? 20 : 0;
    recv_stall_pct <= (mode == MODE_RECEIVER) ? 66 : (mode == MODE_BOTH) ? 20 : 0;
  endtask

  function automatic line_t make_line(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                      input logic [CW-1:0] c, input logic [CW-1:0] d,
                                      input logic [CW-1:0] e, input logic [CW-1:0] f);
    line_t l;
    l.p1_x = a; l.p1_y = b; l.p1_z = c;
    l.p2_x = d; l.p2_y = e; l.p2_z = f;
    return l;
  endfunction

  // mostly moderate coordinates, some full range and some at the rails
  function automatic logic [CW-1:0] rand_coord();
    logic [CW-1:0] v;
    case ($urandom_range(9))
      0: v = C_MIN;
      1: v = C_MAX;
      2, 3, 4: v = $urandom_range(32'h0020_0000) - 32'h0010_0000;
      5, 6: v = $urandom_range(32'h0800_0000) - 32'h0400_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  initial begin
    int phase;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings first
    set_mode(MODE_NONE);
    pending_lines.push_back(make_line('0, '0, '0, '0, '0, '0));
    pending_lines.push_back(make_line(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
    pending_lines.push_back(make_line(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
    pending_lines.push_back(make_line(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN));
    pending_lines.push_back(make_line(C_ONE, '0, -C_ONE, '0, C_ONE, C_ONE));
    pending_lines.push_back(make_line(C_HALF, -C_HALF, 32'sd1, -32'sd1, C_HALF, -C_HALF));
    wait_drained();

    // oblique angles with the camera at the rails, so every stage can overflow
    write_all(C_MAX, C_MIN, C_MAX, 32'h0000_2000, 32'h0000_E000, 32'h0000_6000);
    pending_lines.push_back(make_line(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
    pending_lines.push_back(make_line(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
    pending_lines.push_back(make_line(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX));
    pending_lines.push_back(make_line(C_ONE, C_ONE, C_ONE, -C_ONE, -C_ONE, -C_ONE));
    pending_lines.push_back(make_line(C_HALF, 32'sd1, -32'sd1, '0, -C_HALF, C_HALF));
    pending_lines.push_back(make_line('0, '0, '0, '0, '0, '0));
    wait_drained();

    // upper data bits on angle writes and writes to unmapped indexes must be ignored
    write_all('0, C_ONE, C_MIN, 32'hFFFF_FFFF, 32'hA5A5_0001, 32'h1234_8000);
    write_reg(IDX_SPARE_A, 32'hFFFF_FFFF);
    write_reg(IDX_SPARE_B, $urandom);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    pending_lines.push_back(make_line(C_ONE, C_ONE, C_ONE, C_ONE, C_ONE, C_ONE));
    pending_lines.push_back(make_line(C_MAX, '0, C_MIN, '0, C_MAX, '0));
    pending_lines.push_back(make_line(-C_ONE, 32'sd3, C_MAX, 32'sd7, -C_ONE, C_MIN));
    pending_lines.push_back(make_line('0, '0, C_MIN, '0, '0, C_MIN));
    wait_drained();

    // random phases: each drains fully before the next settings go in
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: write_all('0, '0, '0, '0, '0, '0);
        1: write_all(C_MAX, C_MAX, C_MAX, 32'hFFFF, 32'hFFFF, 32'hFFFF);
        2: write_all(C_MIN, C_MIN, C_MIN, 32'h8000, 32'h4000, 32'hC000);
        3: write_all(rand_coord(), rand_coord(), C_MIN, 32'h0001, 32'h8001, 32'h7FFF);
        default: write_all(rand_coord(), rand_coord(), rand_coord(), $urandom, $urandom,
                           $urandom);
      endcase
      set_mode(phase % 4);
      repeat (PHASE_ITEMS)
        pending_lines.push_back(make_line(rand_coord(), rand_coord(), rand_coord(),
                                          rand_coord(), rand_coord(), rand_coord()));
      wait_drained();
    end

    if (err_count == 0) begin
      $display("line_endpoint_camera_rotation_test: done, clean");
    end else begin
      $display("line_endpoint_camera_rotation_test: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("line_endpoint_camera_rotation_test: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+design
design/lecr_pkg.sv
design/lecr_rot.sv
design/line_endpoint_camera_rotation.sv
tb/line_endpoint_camera_rotation_test.sv
